// ----- src/dabuf_pkg.sv -----
`default_nettype none

package dabuf_pkg;

   localparam int DATA_W     = 32;
   localparam int GW_IN_W    = 2;
   localparam int RATE_W     = 8;
   localparam int FLUSH_W    = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_PAD_W  = RSP_DATA_W - DATA_W - GW_IN_W;
   localparam int MS_PER_S   = 1000;

   localparam logic [RATE_W-1:0]  RATE_RESET  = 8'd1;
   localparam logic [FLUSH_W-1:0] FLUSH_RESET = 5'd4;
   localparam logic [DATA_W-1:0]  EARLY_RESET = 32'd18900;
   localparam logic [DATA_W-1:0]  LATE_RESET  = 32'd48500;

   localparam logic [CSR_IDX_W-1:0] CSR_RATE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLUSH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EARLY = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LATE  = 2'd3;

   localparam logic KIND_DROP = 1'b0;
   localparam logic KIND_FWD  = 1'b1;

   typedef struct packed {
      logic accept;
      logic div_step;
      logic win_load;
      logic rd_en;
      logic scan_eval;
      logic decide;
      logic idx_clear;
      logic drop_eval;
      logic arr_store;
      logic arr_emit;
      logic fwd_eval;
   } ctrl_cmd_type;

   typedef struct packed {
      logic gw_ok;
      logic early;
      logic div_last;
      logic cnt_zero;
      logic idx_last;
      logic any_drops;
      logic flush;
      logic kept_zero;
      logic rd_expired;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- src/dabuf_ram.sv -----
`default_nettype none

module dabuf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/dabuf_ctrl.sv -----
`default_nettype none

module dabuf_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   output dabuf_pkg::ctrl_cmd_type       cmd,
   input  wire dabuf_pkg::dp_status_type status
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_WIN,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_DECIDE,
      ST_DROP_RD,
      ST_DROP_EV,
      ST_ARR,
      ST_FWD_RD,
      ST_FWD_EV
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_START;
            end
         end
         ST_START: begin
            if (!status.gw_ok) begin
               state_in = ST_IDLE;
            end else if (status.early) begin
               state_in = ST_DECIDE;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_WIN;
            end
         end
         ST_WIN: begin
            cmd.win_load = 1'b1;
            state_in     = status.cnt_zero ? ST_DECIDE : ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_SCAN_EV;
         end
         ST_SCAN_EV: begin
            cmd.scan_eval = 1'b1;
            state_in      = status.idx_last ? ST_DECIDE : ST_SCAN_RD;
         end
         ST_DECIDE: begin
            cmd.decide    = 1'b1;
            cmd.idx_clear = 1'b1;
            state_in      = status.any_drops ? ST_DROP_RD : ST_ARR;
         end
         ST_DROP_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_DROP_EV;
         end
         ST_DROP_EV: begin
            if (!status.rd_expired || status.out_free) begin
               cmd.drop_eval = 1'b1;
               state_in      = status.idx_last ? ST_ARR : ST_DROP_RD;
            end
         end
         ST_ARR: begin
            if (!status.flush) begin
               cmd.arr_store = 1'b1;
               state_in      = ST_IDLE;
            end else if (status.out_free) begin
               cmd.arr_emit  = 1'b1;
               cmd.idx_clear = 1'b1;
               state_in      = status.kept_zero ? ST_IDLE : ST_FWD_RD;
            end
         end
         ST_FWD_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_FWD_EV;
         end
         ST_FWD_EV: begin
            if (status.rd_expired || status.out_free) begin
               cmd.fwd_eval = 1'b1;
               state_in     = status.idx_last ? ST_IDLE : ST_FWD_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/dabuf_dp.sv -----
`default_nettype none

module dabuf_dp #(
   parameter int NUM_GATEWAYS = 4,
   parameter int BUFFER_DEPTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [dabuf_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic      [dabuf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                      rsp_tuser,
   output logic                                      rsp_tlast,
   input  wire logic                                 csr_we,
   input  wire logic [dabuf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [dabuf_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire dabuf_pkg::ctrl_cmd_type              cmd,
   output dabuf_pkg::dp_status_type                  status
);

   localparam int DATA_W    = dabuf_pkg::DATA_W;
   localparam int GW_IN_W   = dabuf_pkg::GW_IN_W;
   localparam int RATE_W    = dabuf_pkg::RATE_W;
   localparam int FLUSH_W   = dabuf_pkg::FLUSH_W;
   localparam int CNT_W     = $clog2(BUFFER_DEPTH + 1);
   localparam int IDX_W     = $clog2(BUFFER_DEPTH);
   localparam int GW_W      = (NUM_GATEWAYS > 1) ? $clog2(NUM_GATEWAYS) : 1;
   localparam int RAM_DEPTH = NUM_GATEWAYS * (2 ** IDX_W);
   localparam int ADDR_W    = $clog2(RAM_DEPTH);
   localparam int DIV_CT_W  = $clog2(CNT_W);
   localparam int CMP_W     = (CNT_W > FLUSH_W) ? CNT_W : FLUSH_W;
   localparam int WIN_W     = DATA_W + 1;

   // configuration
   logic [RATE_W-1:0]  rate_ff,  rate_in;
   logic [FLUSH_W-1:0] flush_count_ff, flush_count_in;
   logic [DATA_W-1:0]  early_ff, early_in;
   logic [DATA_W-1:0]  late_ff,  late_in;

   // per gateway fill
   logic [CNT_W-1:0] entry_count_ff [NUM_GATEWAYS];
   logic [CNT_W-1:0] entry_count_in [NUM_GATEWAYS];

   // current item
   logic [GW_IN_W-1:0] gw_ff,  gw_in;
   logic [DATA_W-1:0]  arr_ff, arr_in;
   logic [DATA_W-1:0]  now_ff, now_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   // sequencing counters
   logic [CNT_W-1:0] idx_ff,      idx_in;
   logic [CNT_W-1:0] drops_ff,    drops_in;
   logic [CNT_W-1:0] due_ff,      due_in;
   logic [CNT_W-1:0] kept_idx_ff, kept_idx_in;
   logic [CNT_W-1:0] emit_ct_ff,  emit_ct_in;
   logic             flush_ff,    flush_in;

   // window divider
   logic [CNT_W-1:0]    div_sh_ff, div_sh_in;
   logic [RATE_W-1:0]   rem_ff,    rem_in;
   logic [CNT_W-1:0]    quo_ff,    quo_in;
   logic [DIV_CT_W-1:0] div_ct_ff, div_ct_in;
   logic [WIN_W-1:0]    window_ff, window_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff,  rsp_kind_in;
   logic               rsp_last_ff,  rsp_last_in;
   logic [GW_IN_W-1:0] rsp_gw_ff,    rsp_gw_in;
   logic [DATA_W-1:0]  rsp_dl_ff,    rsp_dl_in;

   logic [GW_IN_W-1:0] req_gw;
   logic [DATA_W-1:0]  req_arr;
   logic [DATA_W-1:0]  req_now;
   logic               req_gw_ok;
   logic [GW_W-1:0]    req_gw_idx;
   logic [GW_W-1:0]    gw_idx;

   logic [RATE_W-1:0]  rate_eff;
   logic [RATE_W:0]    div_trial;
   logic               div_ge;
   logic [WIN_W-1:0]   win_prod;
   logic               early;
   logic               late;
   logic               rd_expired;
   logic [CNT_W-1:0]   kept;
   logic [CNT_W-1:0]   idx_next;
   logic [CNT_W-1:0]   emit_next;
   logic               out_free;
   logic               push;

   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [DATA_W-1:0]  ram_wr_data;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [DATA_W-1:0]  rd_data;

   assign req_gw     = req_tdata[GW_IN_W-1:0];
   assign req_arr    = req_tdata[GW_IN_W +: DATA_W];
   assign req_now    = req_tdata[GW_IN_W + DATA_W +: DATA_W];
   assign req_gw_ok  = int'(req_gw) < NUM_GATEWAYS;
   assign req_gw_idx = GW_W'(req_gw);
   assign gw_idx     = GW_W'(gw_ff);

   assign rate_eff   = (rate_ff == '0) ? RATE_W'(1) : rate_ff;
   assign div_trial  = {rem_ff, div_sh_ff[CNT_W-1]};
   assign div_ge     = div_trial >= {1'b0, rate_eff};
   assign win_prod   = WIN_W'(quo_ff) * WIN_W'(dabuf_pkg::MS_PER_S);
   assign early      = now_ff > early_ff;
   assign late       = now_ff > late_ff;
   assign rd_expired = !early && (rd_data < now_ff);
   assign kept       = cnt_ff - drops_ff;
   assign idx_next   = idx_ff + CNT_W'(1);
   assign emit_next  = emit_ct_ff + CNT_W'(1);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign ram_rd_addr = ADDR_W'({gw_idx, idx_ff[IDX_W-1:0]});

   always_comb begin
      rate_in        = rate_ff;
      flush_count_in = flush_count_ff;
      early_in       = early_ff;
      late_in        = late_ff;
      if (csr_we) begin
         unique case (csr_index)
            dabuf_pkg::CSR_RATE:  rate_in        = csr_wdata[RATE_W-1:0];
            dabuf_pkg::CSR_FLUSH: flush_count_in = csr_wdata[FLUSH_W-1:0];
            dabuf_pkg::CSR_EARLY: early_in       = csr_wdata[DATA_W-1:0];
            dabuf_pkg::CSR_LATE:  late_in        = csr_wdata[DATA_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      entry_count_in = entry_count_ff;
      gw_in          = gw_ff;
      arr_in         = arr_ff;
      now_in         = now_ff;
      cnt_in         = cnt_ff;
      idx_in         = idx_ff;
      drops_in       = drops_ff;
      due_in         = due_ff;
      kept_idx_in    = kept_idx_ff;
      emit_ct_in     = emit_ct_ff;
      flush_in       = flush_ff;
      div_sh_in      = div_sh_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      div_ct_in      = div_ct_ff;
      window_in      = window_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = ADDR_W'({gw_idx, kept_idx_ff[IDX_W-1:0]});
      ram_wr_data    = rd_data;
      push           = 1'b0;
      rsp_kind_in    = rsp_kind_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_gw_in      = rsp_gw_ff;
      rsp_dl_in      = rsp_dl_ff;

      if (cmd.accept) begin
         gw_in       = req_gw;
         arr_in      = req_arr;
         now_in      = req_now;
         cnt_in      = req_gw_ok ? entry_count_ff[req_gw_idx] : '0;
         div_sh_in   = cnt_in;
         idx_in      = '0;
         drops_in    = '0;
         due_in      = '0;
         kept_idx_in = '0;
         emit_ct_in  = '0;
         rem_in      = '0;
         quo_in      = '0;
         div_ct_in   = '0;
      end

      if (cmd.div_step) begin
         rem_in    = div_ge ? RATE_W'(div_trial - {1'b0, rate_eff})
                            : div_trial[RATE_W-1:0];
         quo_in    = {quo_ff[CNT_W-2:0], div_ge};
         div_sh_in = {div_sh_ff[CNT_W-2:0], 1'b0};
         div_ct_in = div_ct_ff + DIV_CT_W'(1);
      end

      if (cmd.win_load) begin
         window_in = {1'b0, now_ff} + win_prod;
      end

      if (cmd.scan_eval) begin
         idx_in = idx_next;
         if (rd_expired) begin
            drops_in = drops_ff + CNT_W'(1);
         end else if ({1'b0, rd_data} < window_ff) begin
            due_in = due_ff + CNT_W'(1);
         end
      end

      if (cmd.decide) begin
         flush_in = early
                 || (CMP_W'(due_ff) >= CMP_W'(flush_count_ff))
                 || late
                 || (kept == CNT_W'(BUFFER_DEPTH));
      end

      if (cmd.idx_clear) begin
         idx_in     = '0;
         emit_ct_in = '0;
      end

      if (cmd.drop_eval) begin
         idx_in = idx_next;
         if (rd_expired) begin
            push        = 1'b1;
            rsp_kind_in = dabuf_pkg::KIND_DROP;
            rsp_dl_in   = rd_data;
            rsp_last_in = (emit_next == drops_ff) && !flush_ff;
            emit_ct_in  = emit_next;
         end else if (!flush_ff) begin
            ram_wr_en   = 1'b1;
            kept_idx_in = kept_idx_ff + CNT_W'(1);
         end
      end

      if (cmd.arr_store) begin
         ram_wr_en              = 1'b1;
         ram_wr_addr            = ADDR_W'({gw_idx, kept[IDX_W-1:0]});
         ram_wr_data            = arr_ff;
         entry_count_in[gw_idx] = kept + CNT_W'(1);
      end

      if (cmd.arr_emit) begin
         push                   = 1'b1;
         rsp_kind_in            = dabuf_pkg::KIND_FWD;
         rsp_dl_in              = arr_ff;
         rsp_last_in            = (kept == '0);
         entry_count_in[gw_idx] = '0;
      end

      if (cmd.fwd_eval) begin
         idx_in = idx_next;
         if (!rd_expired) begin
            push        = 1'b1;
            rsp_kind_in = dabuf_pkg::KIND_FWD;
            rsp_dl_in   = rd_data;
            rsp_last_in = (emit_next == kept);
            emit_ct_in  = emit_next;
         end
      end

      if (push) begin
         rsp_gw_in = gw_ff;
      end
      rsp_valid_in = push || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff        <= dabuf_pkg::RATE_RESET;
         flush_count_ff <= dabuf_pkg::FLUSH_RESET;
         early_ff       <= dabuf_pkg::EARLY_RESET;
         late_ff        <= dabuf_pkg::LATE_RESET;
         for (int g = 0; g < NUM_GATEWAYS; g++) begin
            entry_count_ff[g] <= '0;
         end
         cnt_ff       <= '0;
         idx_ff       <= '0;
         drops_ff     <= '0;
         due_ff       <= '0;
         kept_idx_ff  <= '0;
         emit_ct_ff   <= '0;
         flush_ff     <= 1'b0;
         div_ct_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rate_ff        <= rate_in;
         flush_count_ff <= flush_count_in;
         early_ff       <= early_in;
         late_ff        <= late_in;
         entry_count_ff <= entry_count_in;
         cnt_ff         <= cnt_in;
         idx_ff         <= idx_in;
         drops_ff       <= drops_in;
         due_ff         <= due_in;
         kept_idx_ff    <= kept_idx_in;
         emit_ct_ff     <= emit_ct_in;
         flush_ff       <= flush_in;
         div_ct_ff      <= div_ct_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      gw_ff       <= gw_in;
      arr_ff      <= arr_in;
      now_ff      <= now_in;
      div_sh_ff   <= div_sh_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      window_ff   <= window_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
      rsp_gw_ff   <= rsp_gw_in;
      rsp_dl_ff   <= rsp_dl_in;
   end

   dabuf_ram #(
      .WIDTH (DATA_W),
      .DEPTH (RAM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_data)
   );

   assign status.gw_ok      = int'(gw_ff) < NUM_GATEWAYS;
   assign status.early      = early;
   assign status.div_last   = (div_ct_ff == DIV_CT_W'(CNT_W - 1));
   assign status.cnt_zero   = (cnt_ff == '0);
   assign status.idx_last   = (idx_next == cnt_ff);
   assign status.any_drops  = (drops_ff != '0);
   assign status.flush      = flush_ff;
   assign status.kept_zero  = (kept == '0);
   assign status.rd_expired = rd_expired;
   assign status.out_free   = out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{dabuf_pkg::RSP_PAD_W{1'b0}}, rsp_dl_ff, rsp_gw_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("result pushed while output register busy");

   a_store_room: assert property (@(posedge clock) disable iff (reset)
      cmd.arr_store |-> (kept < CNT_W'(BUFFER_DEPTH)))
      else $error("arrival stored into a full buffer");

   a_drops_bound: assert property (@(posedge clock) disable iff (reset)
      drops_ff <= cnt_ff)
      else $error("more drops than buffered entries");

   a_drop_emit: assert property (@(posedge clock) disable iff (reset)
      (cmd.drop_eval && rd_expired) |-> (emit_ct_ff < drops_ff))
      else $error("drop pass found more expired entries than the scan");

   a_window: assert property (@(posedge clock) disable iff (reset)
      cmd.win_load |=> (window_ff >= {1'b0, now_ff}))
      else $error("window end below current time");

endmodule

`default_nettype wire

// ----- src/deadline_aware_aggregation_buffer.sv -----
`default_nettype none

// Per-gateway deadline buffer. An arrival is taken only when the block is idle; it then
// goes through entry and gateway check, the window division, the window, a scan of the
// buffered entries, the decision, a drop pass (only when something expired), the arrival
// and, on a flush, forwarding of the buffered entries (expired ones are read and
// skipped), plus any stalls on the result side. Past the early flush time the division,
// window and scan are skipped. Each pass visits every entry once, with a read state and
// an evaluate state per entry, since the single deadline RAM has a registered read. An
// arrival for a gateway at or above NUM_GATEWAYS gives no result. Results are drops
// (tuser 0) and forwards (tuser 1); tlast marks the final result of an arrival.

module deadline_aware_aggregation_buffer #(
   parameter int NUM_GATEWAYS = 4,
   parameter int BUFFER_DEPTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // gateway[1:0], arrival_deadline_ms[33:2], now_ms[65:34], zero pad
   input  wire logic [dabuf_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // out_gateway[1:0], entry_deadline_ms[33:2], zero pad
   output logic      [dabuf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // kind[0]
   output logic                                      rsp_tuser,
   output logic                                      rsp_tlast,
   input  wire logic                                 csr_we,
   input  wire logic [dabuf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [dabuf_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   dabuf_pkg::ctrl_cmd_type  cmd;
   dabuf_pkg::dp_status_type status;

   dabuf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   dabuf_dp #(
      .NUM_GATEWAYS (NUM_GATEWAYS),
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

`default_nettype wire

// ----- bench/deadline_aware_aggregation_buffer_tb.sv -----
`timescale 1ns / 100ps

module deadline_aware_aggregation_buffer_tb;

   localparam int DATA_W        = dabuf_pkg::DATA_W;
   localparam int GW_IN_W       = dabuf_pkg::GW_IN_W;
   localparam int RATE_W        = dabuf_pkg::RATE_W;
   localparam int FLUSH_W       = dabuf_pkg::FLUSH_W;
   localparam int CSR_IDX_W     = dabuf_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W    = dabuf_pkg::CSR_DATA_W;
   localparam int REQ_DATA_W    = dabuf_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W    = dabuf_pkg::RSP_DATA_W;
   localparam int NUM_GW        = 4;
   localparam int DEPTH         = 16;
   localparam int REQ_USED_W    = GW_IN_W + 2 * DATA_W;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 150;
   localparam int QUIET_LIMIT   = 5000;
   localparam int PRINT_LIMIT   = 100;

   typedef struct packed {
      logic              kind;
      logic [1:0]        gw;
      logic [DATA_W-1:0] deadline;
      logic              last;
   } entry_result_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   logic [RATE_W-1:0]  cfg_rate  = dabuf_pkg::RATE_RESET;
   logic [FLUSH_W-1:0] cfg_flush = dabuf_pkg::FLUSH_RESET;
   logic [DATA_W-1:0]  cfg_early = dabuf_pkg::EARLY_RESET;
   logic [DATA_W-1:0]  cfg_late  = dabuf_pkg::LATE_RESET;

   logic [DATA_W-1:0] buffered_deadline [NUM_GW][DEPTH];
   int                buffered_count [NUM_GW];
   entry_result_type  expected_entries [$];
   entry_result_type  oldest;

   int mismatch_count  = 0;
   int quiet_cycles    = 0;
   int hold_requests   = 0;
   bit source_throttle = 1'b1;
   bit sink_throttle   = 1'b1;

   deadline_aware_aggregation_buffer #(
      .NUM_GATEWAYS(NUM_GW),
      .BUFFER_DEPTH(DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void predict_arrival(input logic [1:0] gw,
                                           input logic [DATA_W-1:0] arrival,
                                           input logic [DATA_W-1:0] now);
      entry_result_type batch [0:DEPTH];
      int               n;
      int               cnt;
      int               kept;
      int               due;
      int               rate;
      logic [63:0]      window_end;
      bit               flush;
      n   = 0;
      cnt = buffered_count[gw];
      if (now > cfg_early) begin
         flush = 1'b1;
      end else begin
         rate = (cfg_rate == '0) ? 1 : int'(cfg_rate);
         window_end = 64'(now) + 64'(dabuf_pkg::MS_PER_S * (cnt / rate));
         kept = 0;
         for (int i = 0; i < cnt; i++) begin
            if (buffered_deadline[gw][i] < now) begin
               batch[n] = '{dabuf_pkg::KIND_DROP, gw, buffered_deadline[gw][i], 1'b0};
               n++;
            end else begin
               buffered_deadline[gw][kept] = buffered_deadline[gw][i];
               kept++;
            end
         end
         cnt = kept;
         due = 0;
         for (int i = 0; i < cnt; i++)
            if (64'(buffered_deadline[gw][i]) < window_end)
               due++;
         flush = (due >= int'(cfg_flush)) || (now > cfg_late) || (cnt >= DEPTH);
      end
      if (flush) begin
         batch[n] = '{dabuf_pkg::KIND_FWD, gw, arrival, 1'b0};
         n++;
         for (int i = 0; i < cnt; i++) begin
            batch[n] = '{dabuf_pkg::KIND_FWD, gw, buffered_deadline[gw][i], 1'b0};
            n++;
         end
         cnt = 0;
      end else begin
         buffered_deadline[gw][cnt] = arrival;
         cnt++;
      end
      buffered_count[gw] = cnt;
      if (n > 0)
         batch[n-1].last = 1'b1;
      for (int i = 0; i < n; i++)
         expected_entries.insert(expected_entries.size(), batch[i]);
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
   endtask

   task automatic send_arrival(input logic [1:0] gw, input logic [DATA_W-1:0] deadline,
                               input logic [DATA_W-1:0] now);
      while (source_throttle && $urandom_range(0, 99) < 38) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - REQ_USED_W){1'b0}}, now, deadline, gw};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_arrival(gw, deadline, now);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_entries.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         dabuf_pkg::CSR_RATE:  cfg_rate  = value[RATE_W-1:0];
         dabuf_pkg::CSR_FLUSH: cfg_flush = value[FLUSH_W-1:0];
         dabuf_pkg::CSR_EARLY: cfg_early = value;
         dabuf_pkg::CSR_LATE:  cfg_late  = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic configure(input logic [RATE_W-1:0] rate, input logic [FLUSH_W-1:0] flush,
                            input logic [DATA_W-1:0] early, input logic [DATA_W-1:0] late);
      drain_results();
      write_csr(dabuf_pkg::CSR_RATE, CSR_DATA_W'(rate));
      write_csr(dabuf_pkg::CSR_FLUSH, CSR_DATA_W'(flush));
      write_csr(dabuf_pkg::CSR_EARLY, early);
      write_csr(dabuf_pkg::CSR_LATE, late);
   endtask

   task automatic run_traffic(input logic [RATE_W-1:0] rate, input logic [FLUSH_W-1:0] flush,
                              input logic [DATA_W-1:0] early, input logic [DATA_W-1:0] late,
                              input logic [DATA_W-1:0] t_base, input int n_items,
                              input int noise_pct, input int dl_span);
      logic [DATA_W-1:0] wall_ms;
      logic [DATA_W-1:0] deadline;
      logic [DATA_W-1:0] now;
      logic [1:0]        gw;
      configure(rate, flush, early, late);
      wall_ms = t_base;
      repeat (n_items) begin
         wall_ms = wall_ms + $urandom_range(0, 300);
         gw = 2'($urandom_range(0, NUM_GW - 1));
         if ($urandom_range(0, 99) < noise_pct) begin
            deadline = $urandom;
            now      = $urandom;
         end else begin
            now = wall_ms;
            if ($urandom_range(0, 99) < 15)
               deadline = wall_ms - $urandom_range(0, 500);
            else
               deadline = wall_ms + $urandom_range(0, dl_span);
         end
         send_arrival(gw, deadline, now);
      end
   endtask

   task automatic test_directed_cases();
      // zero time and both deadline extremes, the first entry expires on the next arrival
      send_arrival(2'd0, 32'd0, 32'd0);
      send_arrival(2'd0, 32'hFFFF_FFFF, 32'd10);
      // enough due entries inside the window
      send_arrival(2'd1, 32'd500, 32'd100);
      send_arrival(2'd1, 32'd600, 32'd100);
      send_arrival(2'd1, 32'd700, 32'd100);
      send_arrival(2'd1, 32'd800, 32'd100);
      send_arrival(2'd1, 32'd900, 32'd200);
      // drops followed by a queued arrival
      send_arrival(2'd2, 32'd1000, 32'd0);
      send_arrival(2'd2, 32'd50, 32'd0);
      send_arrival(2'd2, 32'd3000, 32'd0);
      send_arrival(2'd2, 32'd4000, 32'd2000);
      // early flush forwards expired entries as well
      send_arrival(2'd2, 32'd10, 32'd20000);
      // now equal to the early time is not early
      send_arrival(2'd0, 32'd12345, dabuf_pkg::EARLY_RESET);
   endtask

   task automatic test_register_extremes();
      // zero rate and zero threshold
      configure('0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_arrival(2'd3, 32'd77, 32'd5);
      send_arrival(2'd0, 32'd1, 32'd0);
      // late flush boundary
      configure(8'd1, 5'd16, 32'hFFFF_FFFF, 32'd1000);
      send_arrival(2'd3, 32'd5, 32'd1001);
      send_arrival(2'd3, 32'd5, 32'd1000);
      // window end beyond 32 bits
      configure(8'd1, 5'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      repeat (4) send_arrival(2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
   endtask

   task automatic test_full_buffer();
      logic [DATA_W-1:0] t;
      logic [1:0]        gw;
      configure(8'hFF, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      t  = $urandom_range(0, 32'h8000_0000);
      gw = 2'($urandom_range(0, NUM_GW - 1));
      repeat (DEPTH + 1) send_arrival(gw, t + $urandom_range(0, 100000), t);
   endtask

   task automatic test_steady_traffic();
      logic [DATA_W-1:0] t;
      t = $urandom_range(0, 32'hF000_0000);
      run_traffic(8'd1, 5'd4, t + 8000, t + 6000, t, 90, 10, 4000);
   endtask

   task automatic test_unthrottled_traffic();
      logic [DATA_W-1:0] t;
      t = $urandom_range(0, 32'hF000_0000);
      source_throttle = 1'b0;
      sink_throttle   = 1'b0;
      run_traffic(8'($urandom_range(1, 6)), 5'($urandom_range(1, 8)), t + 9000, t + 12000,
                  t, 90, 10, 6000);
      drain_results();
      source_throttle = 1'b1;
      sink_throttle   = 1'b1;
   endtask

   task automatic test_zero_rate_traffic();
      logic [DATA_W-1:0] t;
      t = $urandom_range(0, 32'hF000_0000);
      run_traffic('0, 5'($urandom_range(0, 16)), t + 5000, t + 7000, t, 60, 10, 3000);
   endtask

   task automatic test_random_registers();
      run_traffic(8'($urandom), 5'($urandom), $urandom, $urandom, $urandom, 60, 50, 20000);
   endtask

   task automatic test_backpressure();
      configure(8'd1, 5'd4, 32'd0, 32'd0);
      hold_requests++;
      repeat (30)
         send_arrival(2'($urandom_range(0, NUM_GW - 1)), $urandom,
                      $urandom_range(1, 32'hFFFF_FFFF));
      drain_results();
   endtask

   initial begin : result_sink
      int seen_holds;
      seen_holds = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != seen_holds) begin
            seen_holds = hold_requests;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= !sink_throttle || ($urandom_range(0, 99) >= 38);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_entries.size() == 0) begin
            report_mismatch("unexpected transfer, deadline", rsp_tdata[GW_IN_W +: DATA_W], '0);
         end else begin
            oldest = expected_entries.pop_front();
            if (rsp_tuser !== oldest.kind)
               report_mismatch("kind", DATA_W'(rsp_tuser), DATA_W'(oldest.kind));
            if (rsp_tdata[GW_IN_W-1:0] !== oldest.gw)
               report_mismatch("gateway", DATA_W'(rsp_tdata[GW_IN_W-1:0]), DATA_W'(oldest.gw));
            if (rsp_tdata[GW_IN_W +: DATA_W] !== oldest.deadline)
               report_mismatch("deadline", rsp_tdata[GW_IN_W +: DATA_W], oldest.deadline);
            if (rsp_tlast !== oldest.last)
               report_mismatch("last", DATA_W'(rsp_tlast), DATA_W'(oldest.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      for (int g = 0; g < NUM_GW; g++)
         buffered_count[g] = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_register_extremes();
      test_full_buffer();
      test_steady_traffic();
      test_unthrottled_traffic();
      test_zero_rate_traffic();
      test_random_registers();
      test_backpressure();
      drain_results();
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
src/dabuf_pkg.sv
src/dabuf_ram.sv
src/dabuf_ctrl.sv
src/dabuf_dp.sv
src/deadline_aware_aggregation_buffer.sv
bench/deadline_aware_aggregation_buffer_tb.sv
